// ===== rtl/nhc_pkg.sv =====
// Shared constants, types and fixed-point helpers of the two-link chain thermostat.
package nhc_pkg;

    localparam int ENERGY_W = 48;
    localparam int TEMP_W   = 20;
    localparam int SCALE_W  = 32;
    localparam int STEP_W   = 32;
    localparam int MASS_W   = 48;
    localparam int ATOMS_W  = 21;
    localparam int STATE_W  = 48;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int DOF_W    = 23;
    localparam int KT_W     = 20;
    localparam int FKT_W    = 43;

    localparam logic [63:0] CAP63     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] RGAS_Q40  = 64'd2184954189;
    localparam logic [63:0] LOG2E_Q32 = 64'd6196328019;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
    localparam logic signed [63:0] EXP_LIM = 64'sh0000_0020_0000_0000;
    localparam logic [3:0]  EXP_TERMS = 4'd10;

    localparam logic signed [64:0] MAX47 = 65'sh0_0000_7FFF_FFFF_FFFF;
    localparam logic signed [64:0] MIN47 = -65'sh0_0000_8000_0000_0000;

    localparam logic [STEP_W-1:0] RST_TIME_STEP = 32'd1;
    localparam logic [MASS_W-1:0] RST_MASS      = 48'd65536;
    localparam logic [ATOMS_W-1:0] RST_ATOMS    = 21'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP     = 3'd0,
        CFG_FIRST_MASS    = 3'd1,
        CFG_SECOND_MASS   = 3'd2,
        CFG_ATOM_COUNT    = 3'd3,
        CFG_PERIODIC_MODE = 3'd4
    } cfg_idx_t;

    // right shift applied to the full multiplier product
    typedef enum logic [2:0] {
        SH_0, SH_16, SH_32, SH_33, SH_34, SH_35, SH_48
    } shift_t;

    // floor(acc >> sh), saturated at 2^63-1
    function automatic logic [63:0] sat_shift(input logic [127:0] acc, input shift_t sh);
        logic [127:0] sv;
        case (sh)
            SH_16:   sv = acc >> 16;
            SH_32:   sv = acc >> 32;
            SH_33:   sv = acc >> 33;
            SH_34:   sv = acc >> 34;
            SH_35:   sv = acc >> 35;
            SH_48:   sv = acc >> 48;
            default: sv = acc;
        endcase
        return (|sv[127:63]) ? CAP63 : {1'b0, sv[62:0]};
    endfunction

    function automatic logic signed [63:0] sapply(input logic neg, input logic [63:0] m);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] mag48(input logic [STATE_W-1:0] v);
        logic signed [63:0] w;
        w = {{16{v[STATE_W-1]}}, v};
        return v[STATE_W-1] ? 64'(-w) : 64'(w);
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // state value plus signed update, saturated to the signed 48-bit range
    function automatic logic [STATE_W-1:0] add_sat48(input logic [STATE_W-1:0] v,
                                                    input logic signed [63:0] d);
        logic signed [64:0] sum;
        sum = $signed({{17{v[STATE_W-1]}}, v}) + $signed({d[63], d});
        if (sum > MAX47) begin
            return MAX47[STATE_W-1:0];
        end else if (sum < MIN47) begin
            return MIN47[STATE_W-1:0];
        end
        return sum[STATE_W-1:0];
    endfunction

endpackage

// ===== rtl/nose_hoover_two_chain_thermostat.sv =====
// Top level: two-link Nose-Hoover chain thermostat with one shared multiplier and divider.
//
// Input channel s_*: one item per MD half step, the kinetic energy (Q32.16) and
// the target temperature (1/256 K). Result channel m_*: the velocity scale
// factor (Q2.30) and the rescaled kinetic energy (Q32.16), one result per item.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
//
// Each item runs through a sequencer that drives one 32x32 multiplier (four
// partial products per 64x64 product) and one restoring divider that settles
// one quotient bit per cycle. The five exp evaluations, each with ten Horner
// steps that divide by the term index through a reciprocal multiply, and the
// four force divides dominate the work of an item. s_ready is high only while
// the sequencer is idle, so one item is in work at a time and a new item is
// accepted only once the previous one has been through the sequencer.
//
// The result sits in an output register; the next item is accepted while it
// waits. A stalled receiver holds the sequencer only at the point where a new
// result would overwrite an untaken one.
// Reset (aresetn low, synchronous) zeroes the chain velocities and positions
// and loads the register defaults.
module nose_hoover_two_chain_thermostat (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [nhc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [nhc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [nhc_pkg::ENERGY_W-1:0]      s_kinetic_energy,
    input  logic [nhc_pkg::TEMP_W-1:0]        s_target_temperature,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [nhc_pkg::SCALE_W-1:0]       m_scale_factor,
    output logic [nhc_pkg::ENERGY_W-1:0]      m_scaled_energy
);
    import nhc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_KT, S_FKT, S_DISPATCH,
        S_L2F_A, S_L2F_B, S_KICK2_A, S_KICK2_B, S_KICK1_A, S_KICK1_B,
        S_DAMP_A, S_DAMP_B, S_DAMP_C, S_POS_A, S_POS_B,
        S_SCALE_A, S_SCALE_B, S_SCALE_C, S_SCALE_D,
        S_EXP0, S_EXP1, S_EXP2, S_EXP3, S_EXP4, S_EXP5,
        S_MUL, S_DIV
    } state_t;

    typedef enum logic [2:0] {
        OP_L2FK, OP_DAMP, OP_F1K, OP_POS, OP_SCALE, OP_DONE
    } op_t;

    // ceil(2^48 / n): (m * recip) >> 48 equals floor(m / n) for m below 2^34
    function automatic logic [63:0] horner_recip(input logic [3:0] n);
        case (n)
            4'd2:    return 64'h0000_8000_0000_0000;
            4'd3:    return 64'h0000_5555_5555_5556;
            4'd4:    return 64'h0000_4000_0000_0000;
            4'd5:    return 64'h0000_3333_3333_3334;
            4'd6:    return 64'h0000_2AAA_AAAA_AAAB;
            4'd7:    return 64'h0000_2492_4924_924A;
            4'd8:    return 64'h0000_2000_0000_0000;
            4'd9:    return 64'h0000_1C71_C71C_71C8;
            4'd10:   return 64'h0000_1999_9999_999A;
            default: return 64'h0001_0000_0000_0000;
        endcase
    endfunction

    // configuration
    logic [STEP_W-1:0]  time_step_reg;
    logic [MASS_W-1:0]  first_mass_reg, second_mass_reg;
    logic [ATOMS_W-1:0] atom_count_reg;
    logic               periodic_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg     <= RST_TIME_STEP;
            first_mass_reg    <= RST_MASS;
            second_mass_reg   <= RST_MASS;
            atom_count_reg    <= RST_ATOMS;
            periodic_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_TIME_STEP:     time_step_reg     <= cfg_wdata[STEP_W-1:0];
                CFG_FIRST_MASS:    first_mass_reg    <= cfg_wdata[MASS_W-1:0];
                CFG_SECOND_MASS:   second_mass_reg   <= cfg_wdata[MASS_W-1:0];
                CFG_ATOM_COUNT:    atom_count_reg    <= cfg_wdata[ATOMS_W-1:0];
                CFG_PERIODIC_MODE: periodic_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [DOF_W-1:0] dof_tri, dof_sub, dof;
    assign dof_tri = {1'b0, atom_count_reg, 1'b0} + {2'b0, atom_count_reg};
    assign dof_sub = periodic_mode_reg ? DOF_W'(3) : DOF_W'(6);
    assign dof     = (dof_tri > dof_sub) ? dof_tri - dof_sub : '0;

    logic [63:0] dt64, m1_div, m2_div;
    assign dt64   = {32'b0, time_step_reg};
    assign m1_div = (first_mass_reg == '0) ? 64'd1 : {16'b0, first_mass_reg};
    assign m2_div = (second_mass_reg == '0) ? 64'd1 : {16'b0, second_mass_reg};

    // sequencer registers
    state_t state_reg, state_next;
    state_t mul_ret_reg, mul_ret_next, div_ret_reg, div_ret_next, exp_ret_reg, exp_ret_next;
    logic [3:0]  pc_reg, pc_next;
    logic        neg_reg, neg_next;
    logic [ENERGY_W-1:0] ek_reg, ek_next;
    logic [KT_W-1:0]     kt_reg, kt_next;
    logic [FKT_W-1:0]    fkt_reg, fkt_next;
    logic [STATE_W-1:0]  v1_reg, v1_next, v2_reg, v2_next, x1_reg, x1_next, x2_reg, x2_next;
    logic [63:0]         s_reg, s_next;

    // shared multiplier
    logic [63:0]  mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    shift_t       mul_sh_reg, mul_sh_next;
    logic [1:0]   mul_cnt_reg, mul_cnt_next;
    logic [127:0] mul_acc_reg, mul_acc_next;

    // shared divider
    logic [95:0] div_num_reg, div_num_next;
    logic [47:0] div_den_reg, div_den_next, div_rem_reg, div_rem_next;
    logic [63:0] div_q_reg, div_q_next;
    logic        div_ovf_reg, div_ovf_next;
    logic [6:0]  div_cnt_reg, div_cnt_next;

    // exp unit state
    logic signed [63:0] exp_x_reg, exp_x_next;
    logic               exp_neg_reg, exp_neg_next;
    logic signed [7:0]  exp_k_reg, exp_k_next;
    logic [31:0]        exp_t_reg, exp_t_next;
    logic [63:0]        exp_p_reg, exp_p_next, exp_res_reg, exp_res_next;
    logic [3:0]         exp_n_reg, exp_n_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [SCALE_W-1:0]  m_scale_reg, m_scale_next;
    logic [ENERGY_W-1:0] m_energy_reg, m_energy_next;

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_scale_factor  = m_scale_reg;
    assign m_scaled_energy = m_energy_reg;

    // datapath results
    logic [63:0]  mul_out, div_out, pp, mul_opa, mul_opb;
    logic [127:0] addend;
    logic [48:0]  div_trial;
    logic         div_ge;

    assign mul_out = sat_shift(mul_acc_reg, mul_sh_reg);
    assign div_out = (div_ovf_reg || div_q_reg[63]) ? CAP63 : div_q_reg;

    always_comb begin
        mul_opa = mul_cnt_reg[1] ? {32'b0, mul_a_reg[63:32]} : {32'b0, mul_a_reg[31:0]};
        mul_opb = (mul_cnt_reg == 2'd1 || mul_cnt_reg == 2'd3) ?
                  {32'b0, mul_b_reg[63:32]} : {32'b0, mul_b_reg[31:0]};
        pp = mul_opa[31:0] * mul_opb[31:0];
        case (mul_cnt_reg)
            2'd0:    addend = {64'b0, pp};
            2'd3:    addend = {pp, 64'b0};
            default: addend = {32'b0, pp, 32'b0};
        endcase
    end

    assign div_trial = {div_rem_reg, div_num_reg[95]};
    assign div_ge    = (div_trial >= {1'b0, div_den_reg});

    op_t op;
    always_comb begin
        case (pc_reg)
            4'd0:    op = OP_L2FK;
            4'd1:    op = OP_DAMP;
            4'd2:    op = OP_F1K;
            4'd3:    op = OP_DAMP;
            4'd4:    op = OP_POS;
            4'd5:    op = OP_SCALE;
            4'd6:    op = OP_DAMP;
            4'd7:    op = OP_F1K;
            4'd8:    op = OP_DAMP;
            4'd9:    op = OP_L2FK;
            default: op = OP_DONE;
        endcase
    end

    always_comb begin
        logic signed [63:0] num;
        logic signed [63:0] xc;
        logic [63:0]        mag;
        logic [31:0]        f0;
        logic [5:0]         k0;
        logic [7:0]         nk;
        logic [63:0]        pnew;

        state_next    = state_reg;
        mul_ret_next  = mul_ret_reg;
        div_ret_next  = div_ret_reg;
        exp_ret_next  = exp_ret_reg;
        pc_next       = pc_reg;
        neg_next      = neg_reg;
        ek_next       = ek_reg;
        kt_next       = kt_reg;
        fkt_next      = fkt_reg;
        v1_next       = v1_reg;
        v2_next       = v2_reg;
        x1_next       = x1_reg;
        x2_next       = x2_reg;
        s_next        = s_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        mul_sh_next   = mul_sh_reg;
        mul_cnt_next  = mul_cnt_reg;
        mul_acc_next  = mul_acc_reg;
        div_num_next  = div_num_reg;
        div_den_next  = div_den_reg;
        div_rem_next  = div_rem_reg;
        div_q_next    = div_q_reg;
        div_ovf_next  = div_ovf_reg;
        div_cnt_next  = div_cnt_reg;
        exp_x_next    = exp_x_reg;
        exp_neg_next  = exp_neg_reg;
        exp_k_next    = exp_k_reg;
        exp_t_next    = exp_t_reg;
        exp_p_next    = exp_p_reg;
        exp_res_next  = exp_res_reg;
        exp_n_next    = exp_n_reg;
        m_valid_next  = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        m_scale_next  = m_scale_reg;
        m_energy_next = m_energy_reg;
        num  = '0;
        xc   = '0;
        mag  = '0;
        f0   = '0;
        k0   = '0;
        nk   = '0;
        pnew = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ek_next      = s_kinetic_energy;
                    mul_a_next   = {44'b0, s_target_temperature};
                    mul_b_next   = RGAS_Q40;
                    mul_sh_next  = SH_0;
                    mul_ret_next = S_KT;
                    state_next   = S_MUL;
                end
            end
            S_KT: begin
                pnew         = mul_out + 64'h8000_0000;
                kt_next      = pnew[51:32];
                mul_a_next   = {41'b0, dof};
                mul_b_next   = {44'b0, pnew[51:32]};
                mul_sh_next  = SH_0;
                mul_ret_next = S_FKT;
                state_next   = S_MUL;
            end
            S_FKT: begin
                fkt_next   = mul_out[FKT_W-1:0];
                pc_next    = '0;
                state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (op)
                    OP_L2FK: begin
                        mul_a_next   = mag48(v1_reg);
                        mul_b_next   = mag48(v1_reg);
                        mul_sh_next  = SH_48;
                        mul_ret_next = S_L2F_A;
                        state_next   = S_MUL;
                    end
                    OP_DAMP: begin
                        neg_next     = v2_reg[STATE_W-1];
                        mul_a_next   = mag48(v2_reg);
                        mul_b_next   = dt64;
                        mul_sh_next  = SH_35;
                        mul_ret_next = S_DAMP_A;
                        state_next   = S_MUL;
                    end
                    OP_F1K: begin
                        num          = $signed({15'b0, ek_reg, 1'b0})
                                     - $signed({21'b0, fkt_reg});
                        mag          = mag64(num);
                        neg_next     = num[63];
                        div_num_next = {mag, 32'b0};
                        div_den_next = m1_div[47:0];
                        div_cnt_next = 7'd96;
                        div_ret_next = S_KICK1_A;
                        state_next   = S_DIV;
                    end
                    OP_POS, OP_SCALE: begin
                        neg_next     = v1_reg[STATE_W-1];
                        mul_a_next   = mag48(v1_reg);
                        mul_b_next   = dt64;
                        mul_sh_next  = SH_33;
                        mul_ret_next = (op == OP_POS) ? S_POS_A : S_SCALE_A;
                        state_next   = S_MUL;
                    end
                    default: begin
                        // hold until the previous result has been taken
                        if (!m_valid_reg || m_ready) begin
                            m_valid_next  = 1'b1;
                            m_scale_next  = (|s_reg[63:34]) ? '1 : s_reg[33:2];
                            m_energy_next = ek_reg;
                            state_next    = S_IDLE;
                        end
                    end
                endcase
            end
            S_L2F_A: begin
                mul_a_next   = {16'b0, first_mass_reg};
                mul_b_next   = mul_out;
                mul_sh_next  = SH_16;
                mul_ret_next = S_L2F_B;
                state_next   = S_MUL;
            end
            S_L2F_B: begin
                num          = $signed(mul_out) - $signed({44'b0, kt_reg});
                mag          = mag64(num);
                neg_next     = num[63];
                div_num_next = {mag, 32'b0};
                div_den_next = m2_div[47:0];
                div_cnt_next = 7'd96;
                div_ret_next = S_KICK2_A;
                state_next   = S_DIV;
            end
            S_KICK2_A, S_KICK1_A: begin
                mul_a_next   = div_out;
                mul_b_next   = dt64;
                mul_sh_next  = SH_34;
                mul_ret_next = (state_reg == S_KICK2_A) ? S_KICK2_B : S_KICK1_B;
                state_next   = S_MUL;
            end
            S_KICK2_B: begin
                v2_next    = add_sat48(v2_reg, sapply(neg_reg, mul_out));
                pc_next    = pc_reg + 4'd1;
                state_next = S_DISPATCH;
            end
            S_KICK1_B: begin
                v1_next    = add_sat48(v1_reg, sapply(neg_reg, mul_out));
                pc_next    = pc_reg + 4'd1;
                state_next = S_DISPATCH;
            end
            S_DAMP_A, S_SCALE_A: begin
                exp_x_next   = sapply(!neg_reg, mul_out);
                exp_ret_next = (state_reg == S_DAMP_A) ? S_DAMP_B : S_SCALE_B;
                state_next   = S_EXP0;
            end
            S_DAMP_B: begin
                neg_next     = v1_reg[STATE_W-1];
                mul_a_next   = mag48(v1_reg);
                mul_b_next   = exp_res_reg;
                mul_sh_next  = SH_32;
                mul_ret_next = S_DAMP_C;
                state_next   = S_MUL;
            end
            S_DAMP_C: begin
                v1_next    = add_sat48('0, sapply(neg_reg, mul_out));
                pc_next    = pc_reg + 4'd1;
                state_next = S_DISPATCH;
            end
            S_POS_A: begin
                x1_next      = add_sat48(x1_reg, sapply(neg_reg, mul_out));
                neg_next     = v2_reg[STATE_W-1];
                mul_a_next   = mag48(v2_reg);
                mul_b_next   = dt64;
                mul_sh_next  = SH_33;
                mul_ret_next = S_POS_B;
                state_next   = S_MUL;
            end
            S_POS_B: begin
                x2_next    = add_sat48(x2_reg, sapply(neg_reg, mul_out));
                pc_next    = pc_reg + 4'd1;
                state_next = S_DISPATCH;
            end
            S_SCALE_B: begin
                s_next       = exp_res_reg;
                mul_a_next   = exp_res_reg;
                mul_b_next   = exp_res_reg;
                mul_sh_next  = SH_32;
                mul_ret_next = S_SCALE_C;
                state_next   = S_MUL;
            end
            S_SCALE_C: begin
                mul_a_next   = {16'b0, ek_reg};
                mul_b_next   = mul_out;
                mul_sh_next  = SH_32;
                mul_ret_next = S_SCALE_D;
                state_next   = S_MUL;
            end
            S_SCALE_D: begin
                ek_next    = (|mul_out[63:48]) ? '1 : mul_out[47:0];
                pc_next    = pc_reg + 4'd1;
                state_next = S_DISPATCH;
            end
            // exp(x): x*log2(e) split into k and f, Horner series of 2^f, then shift by k
            S_EXP0: begin
                if (exp_x_reg > EXP_LIM) begin
                    xc = EXP_LIM;
                end else if (exp_x_reg < -EXP_LIM) begin
                    xc = -EXP_LIM;
                end else begin
                    xc = exp_x_reg;
                end
                exp_neg_next = exp_x_reg[63];
                mul_a_next   = mag64(xc);
                mul_b_next   = LOG2E_Q32;
                mul_sh_next  = SH_32;
                mul_ret_next = S_EXP1;
                state_next   = S_MUL;
            end
            S_EXP1: begin
                f0 = mul_out[31:0];
                k0 = mul_out[37:32];
                if (!exp_neg_reg) begin
                    exp_k_next = $signed({2'b0, k0});
                end else if (f0 != '0) begin
                    exp_k_next = -$signed({2'b0, k0}) - 8'sd1;
                    f0         = -f0;
                end else begin
                    exp_k_next = -$signed({2'b0, k0});
                end
                mul_a_next   = {32'b0, f0};
                mul_b_next   = LN2_Q32;
                mul_sh_next  = SH_32;
                mul_ret_next = S_EXP2;
                state_next   = S_MUL;
            end
            S_EXP2: begin
                exp_t_next   = mul_out[31:0];
                exp_p_next   = ONE_Q32;
                exp_n_next   = EXP_TERMS;
                mul_a_next   = {32'b0, mul_out[31:0]};
                mul_b_next   = ONE_Q32;
                mul_sh_next  = SH_32;
                mul_ret_next = S_EXP3;
                state_next   = S_MUL;
            end
            S_EXP3: begin
                // product stays below 2^34, so the reciprocal multiply is exact
                mul_a_next   = mul_out;
                mul_b_next   = horner_recip(exp_n_reg);
                mul_sh_next  = SH_48;
                mul_ret_next = S_EXP4;
                state_next   = S_MUL;
            end
            S_EXP4: begin
                pnew       = ONE_Q32 + mul_out;
                exp_p_next = pnew;
                if (exp_n_reg == 4'd1) begin
                    state_next = S_EXP5;
                end else begin
                    exp_n_next   = exp_n_reg - 4'd1;
                    mul_a_next   = {32'b0, exp_t_reg};
                    mul_b_next   = pnew;
                    mul_sh_next  = SH_32;
                    mul_ret_next = S_EXP3;
                    state_next   = S_MUL;
                end
            end
            S_EXP5: begin
                if (!exp_k_reg[7]) begin
                    exp_res_next = (exp_k_reg > 8'sd30) ? CAP63 : (exp_p_reg << exp_k_reg[4:0]);
                end else begin
                    nk           = 8'(-exp_k_reg);
                    exp_res_next = (nk >= 8'd64) ? '0 : (exp_p_reg >> nk[5:0]);
                end
                state_next = exp_ret_reg;
            end
            S_MUL: begin
                mul_acc_next = mul_acc_reg + addend;
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd3) begin
                    state_next = mul_ret_reg;
                end
            end
            S_DIV: begin
                div_rem_next = div_ge ? 48'(div_trial - {1'b0, div_den_reg}) : div_trial[47:0];
                div_num_next = {div_num_reg[94:0], 1'b0};
                div_ovf_next = div_ovf_reg | div_q_reg[63];
                div_q_next   = {div_q_reg[62:0], div_ge};
                div_cnt_next = div_cnt_reg - 7'd1;
                if (div_cnt_reg == 7'd1) begin
                    state_next = div_ret_reg;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // every operation start clears the accumulator or the quotient
        if (state_next == S_MUL && state_reg != S_MUL) begin
            mul_acc_next = '0;
            mul_cnt_next = '0;
        end
        if (state_next == S_DIV && state_reg != S_DIV) begin
            div_rem_next = '0;
            div_q_next   = '0;
            div_ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mul_ret_reg  <= S_IDLE;
            div_ret_reg  <= S_IDLE;
            exp_ret_reg  <= S_IDLE;
            pc_reg       <= '0;
            neg_reg      <= 1'b0;
            ek_reg       <= '0;
            kt_reg       <= '0;
            fkt_reg      <= '0;
            v1_reg       <= '0;
            v2_reg       <= '0;
            x1_reg       <= '0;
            x2_reg       <= '0;
            s_reg        <= '0;
            mul_a_reg    <= '0;
            mul_b_reg    <= '0;
            mul_sh_reg   <= SH_0;
            mul_cnt_reg  <= '0;
            mul_acc_reg  <= '0;
            div_num_reg  <= '0;
            div_den_reg  <= 48'd1;
            div_rem_reg  <= '0;
            div_q_reg    <= '0;
            div_ovf_reg  <= 1'b0;
            div_cnt_reg  <= '0;
            exp_x_reg    <= '0;
            exp_neg_reg  <= 1'b0;
            exp_k_reg    <= '0;
            exp_t_reg    <= '0;
            exp_p_reg    <= ONE_Q32;
            exp_res_reg  <= '0;
            exp_n_reg    <= '0;
            m_valid_reg  <= 1'b0;
            m_scale_reg  <= '0;
            m_energy_reg <= '0;
        end else begin
            state_reg    <= state_next;
            mul_ret_reg  <= mul_ret_next;
            div_ret_reg  <= div_ret_next;
            exp_ret_reg  <= exp_ret_next;
            pc_reg       <= pc_next;
            neg_reg      <= neg_next;
            ek_reg       <= ek_next;
            kt_reg       <= kt_next;
            fkt_reg      <= fkt_next;
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            x1_reg       <= x1_next;
            x2_reg       <= x2_next;
            s_reg        <= s_next;
            mul_a_reg    <= mul_a_next;
            mul_b_reg    <= mul_b_next;
            mul_sh_reg   <= mul_sh_next;
            mul_cnt_reg  <= mul_cnt_next;
            mul_acc_reg  <= mul_acc_next;
            div_num_reg  <= div_num_next;
            div_den_reg  <= div_den_next;
            div_rem_reg  <= div_rem_next;
            div_q_reg    <= div_q_next;
            div_ovf_reg  <= div_ovf_next;
            div_cnt_reg  <= div_cnt_next;
            exp_x_reg    <= exp_x_next;
            exp_neg_reg  <= exp_neg_next;
            exp_k_reg    <= exp_k_next;
            exp_t_reg    <= exp_t_next;
            exp_p_reg    <= exp_p_next;
            exp_res_reg  <= exp_res_next;
            exp_n_reg    <= exp_n_next;
            m_valid_reg  <= m_valid_next;
            m_scale_reg  <= m_scale_next;
            m_energy_reg <= m_energy_next;
        end
    end

`ifndef SYNTHESIS
    // the divider never runs on a zero divisor
    a_div_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_den_reg != '0))
        else $error("divider started with zero divisor");

    // the Horner series of 2^f lies in [1, 2)
    a_exp_series_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXP5) |-> (exp_p_reg[63:33] == '0 && exp_p_reg[32]))
        else $error("exp series out of range");

    // with a zero step the link-two kick leaves the velocity alone
    a_zero_step_kick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_KICK2_B && time_step_reg == '0) |=> (v2_reg == $past(v2_reg)))
        else $error("zero time step changed link two velocity");

    // a new result only appears when the script has finished
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DISPATCH && $past(pc_reg) == 4'd10))
        else $error("result raised outside end of item");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the two-link Nose-Hoover chain thermostat.
module tb_top;
    import nhc_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 3200;
    localparam int RANDOM_ITEMS   = 1200;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam logic [31:0] SCALE_ONE = 32'h4000_0000;
    localparam logic [47:0] ENERGY_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [SCALE_W-1:0]  scale;
        logic [ENERGY_W-1:0] energy;
    } thermo_result_t;

    typedef struct {
        logic [ENERGY_W-1:0] energy;
        logic [TEMP_W-1:0]   temp;
        bit                  typed;
        thermo_result_t      result;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ENERGY_W-1:0] s_kinetic_energy = '0;
    logic [TEMP_W-1:0] s_target_temperature = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [SCALE_W-1:0] m_scale_factor;
    logic [ENERGY_W-1:0] m_scaled_energy;

    nose_hoover_two_chain_thermostat DUT (.*);

    always #5 aclk = ~aclk;

    // chain model state and register copies
    logic [63:0] dt_reg, q1_reg, q2_reg, atoms_reg, pbc_reg;
    longint v1_st, v2_st, x1_st, x2_st;
    thermo_result_t pending_results[$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;

    function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p > {64'd0, CAP63}) ? CAP63 : p[63:0];
    endfunction

    function automatic logic [63:0] mag(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint signed_of(bit neg, logic [63:0] m);
        if (m > CAP63) m = CAP63;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint smul(longint a, logic [63:0] b, int sh);
        return signed_of(a < 0, mul_shr(mag(a), b, sh));
    endfunction

    function automatic longint sat48(longint v, longint d);
        logic signed [64:0] s;
        s = 65'(v) + 65'(d);
        if (s > MAX47) return longint'(MAX47);
        if (s < MIN47) return longint'(MIN47);
        return longint'(s);
    endfunction

    function automatic longint force_of(longint num, logic [63:0] mass);
        logic [127:0] q;
        logic [63:0] d;
        d = (mass == 0) ? 64'd1 : mass;
        q = {32'd0, mag(num), 32'd0} / {64'd0, d};
        return signed_of(num < 0, (q > {64'd0, CAP63}) ? CAP63 : q[63:0]);
    endfunction

    function automatic logic [63:0] exp_q32(longint x);
        longint lim;
        logic [63:0] ym, f, t, p;
        int k;
        lim = longint'(1) << 37;
        if (x > lim) x = lim;
        if (x < -lim) x = -lim;
        ym = mul_shr(mag(x), LOG2E_Q32, 32);
        f = {32'd0, ym[31:0]};
        k = int'(ym >> 32);
        if (x < 0) begin
            k = -k;
            if (f != 0) begin
                k = k - 1;
                f = ONE_Q32 - f;
            end
        end
        t = mul_shr(f, LN2_Q32, 32);
        p = ONE_Q32;
        for (int n = 10; n >= 1; n--) p = ONE_Q32 + mul_shr(t, p, 32) / 64'(n);
        if (k >= 0) return (k > 30) ? CAP63 : (p << k);
        return (-k >= 64) ? 64'd0 : (p >> (-k));
    endfunction

    function automatic longint link_two_force(longint v1, longint kt);
        logic [63:0] sq, en;
        sq = mul_shr(mag(v1), mag(v1), 48);
        en = mul_shr(q1_reg, sq, 16);
        return force_of(longint'(en) - kt, q2_reg);
    endfunction

    function automatic longint kick(longint v, longint g);
        return sat48(v, smul(g, dt_reg, 34));
    endfunction

    function automatic longint damp(longint v1, longint v2);
        return sat48(0, smul(v1, exp_q32(-smul(v2, dt_reg, 35)), 32));
    endfunction

    // one half step of the chain; updates the model state
    function automatic thermo_result_t thermostat_step(logic [47:0] ek_in, logic [19:0] temp);
        logic [63:0] dof, sub, ek, s, s2, sc;
        longint kt, fkt, v1, v2;
        thermo_result_t r;
        dof = 3 * atoms_reg;
        sub = pbc_reg[0] ? 64'd3 : 64'd6;
        dof = (dof > sub) ? dof - sub : 64'd0;
        kt = longint'(({44'd0, temp} * RGAS_Q40 + 64'h8000_0000) >> 32);
        fkt = longint'(dof) * kt;
        ek = {16'd0, ek_in};
        v1 = v1_st;
        v2 = v2_st;
        v2 = kick(v2, link_two_force(v1, kt));
        v1 = damp(v1, v2);
        v1 = kick(v1, force_of(longint'(2 * ek) - fkt, q1_reg));
        v1 = damp(v1, v2);
        x1_st = sat48(x1_st, smul(v1, dt_reg, 33));
        x2_st = sat48(x2_st, smul(v2, dt_reg, 33));
        s = exp_q32(-smul(v1, dt_reg, 33));
        s2 = mul_shr(s, s, 32);
        ek = mul_shr(ek, s2, 32);
        if (ek > ENERGY_MAX) ek = ENERGY_MAX;
        v1 = damp(v1, v2);
        v1 = kick(v1, force_of(longint'(2 * ek) - fkt, q1_reg));
        v1 = damp(v1, v2);
        v2 = kick(v2, link_two_force(v1, kt));
        v1_st = v1;
        v2_st = v2;
        sc = s >> 2;
        r.scale = (sc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sc[31:0];
        r.energy = ek[47:0];
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val[CFG_W-1:0];
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            CFG_TIME_STEP:     dt_reg = val & 64'hFFFF_FFFF;
            CFG_FIRST_MASS:    q1_reg = val & 64'hFFFF_FFFF_FFFF;
            CFG_SECOND_MASS:   q2_reg = val & 64'hFFFF_FFFF_FFFF;
            CFG_ATOM_COUNT:    atoms_reg = val & 64'h1F_FFFF;
            CFG_PERIODIC_MODE: pbc_reg = val & 64'd1;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // drive one item; called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(logic [47:0] ek, logic [19:0] temp, bit typed, thermo_result_t r);
        thermo_result_t predicted;
        int gap;
        gap = quiet ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                        : $urandom_range(0, 3));
        repeat (gap) @(negedge aclk);
        s_valid = 1'b1;
        s_kinetic_energy = ek;
        s_target_temperature = temp;
        do @(posedge aclk); while (!s_ready);
        predicted = thermostat_step(ek, temp);
        pending_results.push_back(typed ? r : predicted);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic logic [47:0] rand_energy();
        case ($urandom_range(0, 5))
            0: return 48'd0;
            1: return ENERGY_MAX;
            2: return 48'($urandom_range(0, 65535));
            3: return {16'd0, $urandom()};
            default: return {16'($urandom()), $urandom()};
        endcase
    endfunction

    function automatic logic [19:0] rand_temp();
        case ($urandom_range(0, 4))
            0: return 20'd0;
            1: return 20'hFFFFF;
            default: return 20'($urandom());
        endcase
    endfunction

    function automatic logic [63:0] rand_mass();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return 64'hFFFF_FFFF_FFFF;
            2: return 64'd1;
            3: return 64'($urandom_range(1, 32'h00FF_FFFF));
            default: return {16'd0, 16'($urandom()), $urandom()};
        endcase
    endfunction

    // receiver stalls
    always @(negedge aclk) begin
        if (quiet) m_ready <= 1'b1;
        else if ($urandom_range(0, 49) == 0) m_ready <= 1'b0;
        else if ($urandom_range(0, 3) == 0) m_ready <= ~m_ready;
        else m_ready <= ($urandom_range(0, 9) != 0) || m_ready;
    end

    always @(posedge aclk) begin
        thermo_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected item: scale_factor %0h scaled_energy %0h",
                       m_scale_factor, m_scaled_energy);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_scale_factor !== want.scale) begin
                    $error("scale_factor: expected %0h actual %0h", want.scale, m_scale_factor);
                    errors++;
                end
                if (m_scaled_energy !== want.energy) begin
                    $error("scaled_energy: expected %0h actual %0h",
                           want.energy, m_scaled_energy);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    stim_row_t base_rows[] = '{
        '{48'd0, 20'd0, 1'b1, '{SCALE_ONE, 48'd0}},
        '{ENERGY_MAX, 20'd0, 1'b0, '{0, 0}},
        '{48'd0, 20'hFFFFF, 1'b0, '{0, 0}},
        '{ENERGY_MAX, 20'hFFFFF, 1'b0, '{0, 0}},
        '{48'h0000_0001_0000, 20'd76800, 1'b0, '{0, 0}},
        '{48'h5555_5555_5555, 20'hAAAAA, 1'b0, '{0, 0}},
        '{48'hAAAA_AAAA_AAAA, 20'h55555, 1'b0, '{0, 0}},
        '{48'd1, 20'd1, 1'b0, '{0, 0}}
    };
    // zero time step: scale is one and the energy passes through
    stim_row_t hold_rows[] = '{
        '{48'd0, 20'd0, 1'b1, '{SCALE_ONE, 48'd0}},
        '{ENERGY_MAX, 20'hFFFFF, 1'b1, '{SCALE_ONE, ENERGY_MAX}},
        '{48'h1234_5678_9ABC, 20'h12345, 1'b1, '{SCALE_ONE, 48'h1234_5678_9ABC}},
        '{48'h0000_0001_0000, 20'd0, 1'b1, '{SCALE_ONE, 48'h0000_0001_0000}}
    };

    initial begin
        int sent;
        dt_reg = 1;
        q1_reg = 65536;
        q2_reg = 65536;
        atoms_reg = 3;
        pbc_reg = 0;
        v1_st = 0;
        v2_st = 0;
        x1_st = 0;
        x2_st = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (base_rows[i])
            send_item(base_rows[i].energy, base_rows[i].temp, base_rows[i].typed,
                      base_rows[i].result);
        // too few atoms, tiny masses, large step, periodic mode, writes to unused addresses
        wait_drained();
        write_reg(CFG_ATOM_COUNT, 64'd1);
        write_reg(CFG_FIRST_MASS, 64'd0);
        write_reg(CFG_SECOND_MASS, 64'd0);
        write_reg(CFG_TIME_STEP, 64'hFFFF_FFFF);
        write_reg(CFG_PERIODIC_MODE, 64'd1);
        write_reg(CFG_UNUSED_LO, 64'hFFFF_FFFF_FFFF);
        write_reg(CFG_UNUSED_HI, 64'd0);
        foreach (base_rows[i]) if (i > 0)
            send_item(base_rows[i].energy, base_rows[i].temp, 1'b0, base_rows[i].result);
        wait_drained();
        write_reg(CFG_TIME_STEP, 64'd0);
        foreach (hold_rows[i])
            send_item(hold_rows[i].energy, hold_rows[i].temp, 1'b1, hold_rows[i].result);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 4))
                0: write_reg(CFG_TIME_STEP, 64'hFFFF_FFFF);
                1: write_reg(CFG_TIME_STEP, 64'd1);
                2: write_reg(CFG_TIME_STEP, 64'd0);
                default: write_reg(CFG_TIME_STEP, 64'($urandom()));
            endcase
            write_reg(CFG_FIRST_MASS, rand_mass());
            write_reg(CFG_SECOND_MASS, rand_mass());
            case ($urandom_range(0, 3))
                0: write_reg(CFG_ATOM_COUNT, 64'($urandom_range(0, 2)));
                1: write_reg(CFG_ATOM_COUNT, 64'h1F_FFFF);
                default: write_reg(CFG_ATOM_COUNT, 64'($urandom_range(3, 1048576)));
            endcase
            write_reg(CFG_PERIODIC_MODE, 64'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_LO, 64'($urandom()));
            repeat ($urandom_range(40, 120)) begin
                send_item(rand_energy(), rand_temp(), 1'b0, '0);
                sent++;
            end
        end
        quiet = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
